@@ design/slrf_pkg.sv @@
// ----------------------------------------------------------------------------
// slrf_pkg: shared types and constants of the random flicker core
// Level format, register indexes, opcodes and the state/config structs.
// ----------------------------------------------------------------------------
`default_nettype none

package slrf_pkg;

  // Level format: unsigned fixed point, full scale is 1.0
  localparam int unsigned LevelFracBits = 15;
  localparam int unsigned LevelW        = 16;
  localparam logic [LevelW-1:0] FullScale = LevelW'(1 << LevelFracBits);

  localparam int unsigned CycleW   = 16;
  localparam int unsigned EffectW  = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CYCLE_LENGTH  = 2'd0,
    CFG_EFFECT_LENGTH = 2'd1,
    CFG_SLEW_LIMIT    = 2'd2,
    CFG_MIN_LEVEL     = 2'd3
  } cfg_idx_e;

  // Opcodes of an input word
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef struct packed {
    logic [CycleW-1:0]  cycle_length;
    logic [EffectW-1:0] effect_length;
    logic [LevelW-1:0]  slew_limit;
    logic [LevelW-1:0]  min_level;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0]  level;
    logic [LevelW-1:0]  target;
    logic [CycleW-1:0]  cycle_pos;
    logic [EffectW-1:0] elapsed;
    logic               active;
  } state_t;

  // Clamp a level to full scale
  function automatic logic [LevelW-1:0] sat_full(input logic [LevelW-1:0] v);
    return (v > FullScale) ? FullScale : v;
  endfunction

endpackage

`default_nettype wire

@@ design/slrf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// slrf_cfg_regs: configuration register file
// Four registers written through a valid/ready port; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module slrf_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [slrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [slrf_pkg::CfgDataW-1:0] cfg_data_i,
  output slrf_pkg::cfg_t                     cfg_o
);

  slrf_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (slrf_pkg::cfg_idx_e'(cfg_index_i))
        slrf_pkg::CFG_CYCLE_LENGTH:
          cfg_d.cycle_length = cfg_data_i[slrf_pkg::CycleW-1:0];
        slrf_pkg::CFG_EFFECT_LENGTH:
          cfg_d.effect_length = cfg_data_i[slrf_pkg::EffectW-1:0];
        slrf_pkg::CFG_SLEW_LIMIT:
          cfg_d.slew_limit = cfg_data_i[slrf_pkg::LevelW-1:0];
        slrf_pkg::CFG_MIN_LEVEL:
          cfg_d.min_level = cfg_data_i[slrf_pkg::LevelW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycle_length  <= slrf_pkg::CycleW'(1);
      cfg_q.effect_length <= '0;
      cfg_q.slew_limit    <= slrf_pkg::FullScale;
      cfg_q.min_level     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/slrf_step.sv @@
// ----------------------------------------------------------------------------
// slrf_step: next-state logic for one word
// Start or one tick: target draw, slew-limited move, cycle and effect counters.
// ----------------------------------------------------------------------------
`default_nettype none

module slrf_step (
  input  wire slrf_pkg::cfg_t               cfg_i,
  input  wire slrf_pkg::state_t             state_i,
  input  wire logic                         op_i,
  input  wire logic [slrf_pkg::LevelW-1:0]  random_level_i,
  output slrf_pkg::state_t                  state_o
);

  logic [slrf_pkg::LevelW-1:0]  lo, slew, rnd_sat, tgt, diff, step;
  logic [slrf_pkg::CycleW:0]    pos_inc;
  logic [slrf_pkg::EffectW:0]   elap_inc;

  always_comb begin
    lo       = slrf_pkg::sat_full(cfg_i.min_level);
    slew     = slrf_pkg::sat_full(cfg_i.slew_limit);
    rnd_sat  = slrf_pkg::sat_full(random_level_i);
    state_o  = state_i;

    // new target only at the start of a flicker cycle
    tgt = state_i.target;
    if (state_i.cycle_pos == '0) begin
      tgt = (rnd_sat < lo) ? lo : rnd_sat;
    end

    // slew-limited distance toward the target
    diff = (tgt > state_i.level) ? (tgt - state_i.level) : (state_i.level - tgt);
    step = (diff < slew) ? diff : slew;

    pos_inc  = {1'b0, state_i.cycle_pos} + 1'b1;
    elap_inc = {1'b0, state_i.elapsed} + 1'b1;

    if (slrf_pkg::op_e'(op_i) == slrf_pkg::OP_START) begin
      // restart: level midway between min and full scale
      state_o.elapsed   = '0;
      state_o.cycle_pos = '0;
      state_o.level     = lo + ((slrf_pkg::FullScale - lo) >> 1);
      state_o.active    = 1'b1;
    end else if (state_i.active) begin
      state_o.target = tgt;
      if (tgt > state_i.level) begin
        state_o.level = state_i.level + step;
      end else begin
        state_o.level = state_i.level - step;
      end

      // cycle wrap, also when the length was lowered mid-cycle
      state_o.cycle_pos = (pos_inc >= {1'b0, cfg_i.cycle_length}) ?
                          '0 : pos_inc[slrf_pkg::CycleW-1:0];

      // finite effect: count and end
      if (cfg_i.effect_length != '0) begin
        state_o.elapsed = elap_inc[slrf_pkg::EffectW-1:0];
        if (elap_inc >= {1'b0, cfg_i.effect_length}) begin
          state_o.level  = '0;
          state_o.active = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/slew_limited_random_flicker_core.sv @@
// ----------------------------------------------------------------------------
// slew_limited_random_flicker_core: random LED flicker level generator
// Input register, single-pass step logic with state, output register.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries op_i and random_level_i.
//    op_i = start restarts the effect; op_i = tick advances it by one tick
//    using random_level_i as the candidate target.
//  - Output channel (out_valid_o / out_stall_i) returns one word per input:
//    level_o (Q1.15, zero when inactive) and running_o.
//  - Config port (cfg_valid_i / cfg_ready_o) is always ready; write it only
//    while no word is in flight.
//  - Path: an accepted word passes the input register, then the step logic
//    into the output register.
//  - Throughput: one word per cycle while out_stall_i is low; the state update
//    is compare, subtract and add logic between the input and output registers.
//  - Reset: effect inactive, level zero, registers at their defaults
//    (cycle length 1, endless effect, slew full scale, min level 0).
//  - A stalled output holds its word; the input register then fills and
//    in_stall_o rises until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module slew_limited_random_flicker_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [slrf_pkg::LevelW-1:0]   random_level_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [slrf_pkg::LevelW-1:0]        level_o,
  output logic                               running_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [slrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [slrf_pkg::CfgDataW-1:0] cfg_data_i
);

  slrf_pkg::cfg_t   cfg;
  slrf_pkg::state_t state_q, state_d;

  logic                        in_valid_q;
  logic                        op_q;
  logic [slrf_pkg::LevelW-1:0] rnd_q;
  logic                        out_valid_q, running_q;
  logic [slrf_pkg::LevelW-1:0] level_q;
  logic                        out_free, advance, in_take;

  slrf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the output register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_i;
      rnd_q <= random_level_i;
    end
  end

  slrf_step u_step (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .op_i           (op_q),
    .random_level_i (rnd_q),
    .state_o        (state_d)
  );

  // Effect state, updated once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q   <= state_d.active ? state_d.level : '0;
      running_q <= state_d.active;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign running_o   = running_q;

  // Checks
  a_idle_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> level_o == '0)
    else $error("level nonzero while effect inactive");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= slrf_pkg::FullScale && state_q.target <= slrf_pkg::FullScale)
    else $error("level or target above full scale");

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(op_q) && $stable(rnd_q))
    else $error("pending input word lost while output stalled");

  a_inactive_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !state_q.active && op_q == slrf_pkg::OP_TICK |=> $stable(state_q))
    else $error("tick changed state while inactive");

endmodule

`default_nettype wire
